FILE: hdl/iac_pkg.sv
`timescale 1ns / 1ps
package iac_pkg;

  localparam int unsigned NumPaths          = 12;
  localparam int unsigned NumTurns          = 3;
  localparam int unsigned PathIdxW          = 4;
  localparam int unsigned MaxPerPathDefault = 15;
  localparam logic [7:0]  PhaseTicksReset   = 8'd40;

  // direction codes
  localparam logic [1:0] DirNorth = 2'd0;
  localparam logic [1:0] DirSouth = 2'd1;
  localparam logic [1:0] DirEast  = 2'd2;
  localparam logic [1:0] DirWest  = 2'd3;

  // turn codes; code three names no movement
  localparam logic [1:0] TurnStraight = 2'd0;
  localparam logic [1:0] TurnLeft     = 2'd1;
  localparam logic [1:0] TurnRight    = 2'd2;
  localparam logic [1:0] TurnNone     = 2'd3;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_LEAVE   = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_PREEMPT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_NS  = 2'd0,
    PH_EW  = 2'd1,
    PH_EMG = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

  function automatic logic [1:0] exit_of(input logic [1:0] d, input logic [1:0] m);
    logic [1:0] e;
    e = 2'd0;
    if (m == TurnStraight) begin
      e = d ^ 2'b01;
    end else if (m == TurnRight) begin
      case (d)
        DirNorth: e = DirWest;
        DirSouth: e = DirEast;
        DirEast:  e = DirNorth;
        default:  e = DirSouth;
      endcase
    end else begin
      case (d)
        DirNorth: e = DirEast;
        DirSouth: e = DirWest;
        DirEast:  e = DirSouth;
        default:  e = DirNorth;
      endcase
    end
    return e;
  endfunction

  function automatic logic opposite(input logic [1:0] a, input logic [1:0] b);
    return (a ^ b) == 2'b01;
  endfunction

  // left turn from a crosses straight traffic from b
  function automatic logic left_cuts(input logic [1:0] a, input logic [1:0] b);
    return (a == DirNorth && b == DirEast) || (a == DirEast && b == DirSouth) ||
           (a == DirSouth && b == DirWest) || (a == DirWest && b == DirNorth);
  endfunction

  function automatic logic conflicts(input logic [1:0] d1, input logic [1:0] m1,
                                     input logic [1:0] d2, input logic [1:0] m2);
    logic c;
    c = 1'b0;
    if (d1 == d2) begin
      c = 1'b1;
    end else if (exit_of(d1, m1) == exit_of(d2, m2)) begin
      c = 1'b1;
    end else if (m1 == TurnRight || m2 == TurnRight) begin
      c = 1'b0;
    end else if (m1 == TurnStraight && m2 == TurnStraight) begin
      c = !opposite(d1, d2);
    end else if (m1 == TurnLeft && m2 == TurnStraight) begin
      c = left_cuts(d1, d2);
    end else if (m1 == TurnStraight && m2 == TurnLeft) begin
      c = left_cuts(d2, d1);
    end else if (m1 == TurnLeft && m2 == TurnLeft) begin
      c = opposite(d1, d2);
    end
    return c;
  endfunction

endpackage

FILE: hdl/iac_ctrl.sv
`timescale 1ns / 1ps
module iac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iac_pkg::ctrl_cmd_t cmd_o,
  input  iac_pkg::dp_status_t status_i
);
  import iac_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.execute   = (state_q == ST_EXEC) && out_free;
    out_valid_d     = cmd_o.execute || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == ST_SCAN)
    else $error("accepted transaction did not start the scan");

  a_scan_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.scan_last) |=> state_q == ST_EXEC)
    else $error("scan end did not move to update");

  a_exec_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_q)
    else $error("update without a result transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

FILE: hdl/iac_datapath.sv
`timescale 1ns / 1ps
module iac_datapath #(
  parameter int unsigned MaxPerPath = iac_pkg::MaxPerPathDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iac_pkg::ctrl_cmd_t  cmd_i,
  output iac_pkg::dp_status_t status_o,
  input  logic [1:0]          command_i,
  input  logic [1:0]          entry_direction_i,
  input  logic [1:0]          turn_i,
  input  logic                emergency_vehicle_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  output logic                granted_o,
  output logic [1:0]          light_phase_o,
  output logic                emerg_active_o,
  output logic [7:0]          occupancy_total_o
);
  import iac_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPerPath + 1);
  localparam int unsigned OccW = $clog2(NumPaths * MaxPerPath + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPerPath);
  localparam logic [PathIdxW-1:0] LastIdx = PathIdxW'(NumPaths - 1);

  // latched transaction
  cmd_e       cmd_q;
  logic [1:0] dir_q, trn_q;
  logic       emv_q;

  // intersection state
  logic [CntW-1:0] path_q [NumPaths];
  logic [OccW-1:0] occ_q, occ_d;
  phase_e          phase_q, phase_d;
  logic            emerg_q, emerg_d;
  logic            clear_q, clear_d;
  logic [7:0]      timer_q, timer_d;
  logic [7:0]      ticks_q;

  // scan over the path counters
  logic [PathIdxW-1:0] scan_q;
  logic [1:0]          sdir_q, sturn_q;
  logic                conflict_q;
  logic [CntW-1:0]     own_q;
  logic [CntW-1:0]     scan_cnt;
  logic [PathIdxW-1:0] idx;

  // update
  logic            grant;
  logic            below, turn_ok;
  phase_e          want;
  logic            path_wr;
  logic [CntW-1:0] path_wr_val;
  logic [7:0]      timer_inc;
  logic [OccW+7:0] occ_wide;

  logic       out_grant_q;
  phase_e     out_phase_q;
  logic       out_emerg_q;
  logic [7:0] out_occ_q;

  assign idx = {1'b0, dir_q, 1'b0} + {2'b00, dir_q} + {2'b00, trn_q};
  assign scan_cnt = path_q[scan_q];
  assign status_o.scan_last = (scan_q == LastIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= cmd_e'(command_i);
      dir_q <= entry_direction_i;
      trn_q <= turn_i;
      emv_q <= emergency_vehicle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      sdir_q     <= '0;
      sturn_q    <= '0;
      conflict_q <= 1'b0;
      own_q      <= '0;
    end else if (cmd_i.load_in) begin
      scan_q     <= '0;
      sdir_q     <= '0;
      sturn_q    <= '0;
      conflict_q <= 1'b0;
      own_q      <= '0;
    end else if (cmd_i.scan_step) begin
      if (!status_o.scan_last) begin
        scan_q <= scan_q + PathIdxW'(1);
        if (sturn_q == 2'(NumTurns - 1)) begin
          sturn_q <= '0;
          sdir_q  <= sdir_q + 2'd1;
        end else begin
          sturn_q <= sturn_q + 2'd1;
        end
      end
      if (scan_cnt != '0 && conflicts(dir_q, trn_q, sdir_q, sturn_q)) conflict_q <= 1'b1;
      if (scan_q == idx) own_q <= scan_cnt;
    end
  end

  always_comb begin
    path_wr     = 1'b0;
    path_wr_val = own_q;
    occ_d       = occ_q;
    phase_d     = phase_q;
    emerg_d     = emerg_q;
    clear_d     = clear_q;
    timer_d     = timer_q;
    grant       = 1'b0;
    timer_inc   = timer_q + 8'd1;
    below       = own_q < CntMax;
    turn_ok     = (trn_q != TurnNone);
    want        = dir_q[1] ? PH_EW : PH_NS;
    case (cmd_q)
      CMD_REQUEST: begin
        if (turn_ok) begin
          if (emv_q) begin
            if (!emerg_q) begin
              emerg_d = 1'b1;
              clear_d = 1'b1;
              phase_d = PH_EMG;
            end
            if (clear_d) begin
              if (occ_q == '0 && below) begin
                clear_d = 1'b0;
                grant   = 1'b1;
              end
            end else if (below) begin
              grant = 1'b1;
            end
          end else if (!emerg_q && below && phase_q == want && !conflict_q) begin
            grant = 1'b1;
          end
          if (grant) begin
            path_wr     = 1'b1;
            path_wr_val = own_q + CntW'(1);
            occ_d       = occ_q + OccW'(1);
          end
        end
      end
      CMD_LEAVE: begin
        if (turn_ok) begin
          if (own_q != '0) begin
            path_wr     = 1'b1;
            path_wr_val = own_q - CntW'(1);
            occ_d       = occ_q - OccW'(1);
          end
          if (emv_q && emerg_q) begin
            emerg_d = 1'b0;
            clear_d = 1'b0;
            phase_d = PH_NS;
            timer_d = 8'd0;
          end
        end
      end
      CMD_TICK: begin
        if (!emerg_q) begin
          timer_d = timer_inc;
          if (timer_inc >= ticks_q) begin
            phase_d = (phase_q == PH_NS) ? PH_EW : PH_NS;
            timer_d = 8'd0;
          end
        end
      end
      CMD_PREEMPT: begin
        emerg_d = 1'b1;
        phase_d = PH_EMG;
      end
      default: ;
    endcase
    occ_wide = {8'h00, occ_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPaths; i++) path_q[i] <= '0;
      occ_q   <= '0;
      phase_q <= PH_NS;
      emerg_q <= 1'b0;
      clear_q <= 1'b0;
      timer_q <= 8'd0;
    end else if (cmd_i.execute) begin
      if (path_wr) path_q[idx] <= path_wr_val;
      occ_q   <= occ_d;
      phase_q <= phase_d;
      emerg_q <= emerg_d;
      clear_q <= clear_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_grant_q <= grant;
      out_phase_q <= phase_d;
      out_emerg_q <= emerg_d;
      out_occ_q   <= occ_wide[7:0];
    end
  end

  assign granted_o         = out_grant_q;
  assign light_phase_o     = out_phase_q;
  assign emerg_active_o    = out_emerg_q;
  assign occupancy_total_o = out_occ_q;

  a_emerg_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emerg_q |-> phase_q == PH_EMG)
    else $error("emergency active without emergency phase");

  a_clear_needs_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> emerg_q)
    else $error("clearing without emergency");

  a_grant_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && grant) |-> (own_q < CntMax && cmd_q == CMD_REQUEST))
    else $error("grant on a full path or non-request");

endmodule

FILE: hdl/intersection_admission_controller.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   command, entry_direction, turn, emergency_vehicle
// result    out        out_valid_o / out_stall_i granted, light_phase, emerg_active,
//                                                occupancy_total
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (phase_ticks)
//
// One input transaction is accepted, then the 12 path counters are scanned (one counter
// per cycle for the conflict check), then the update is done.
// The update waits while a previous result is still stalled in the output register.
// Reset (rst_ni low, asynchronous) empties all paths, selects green north-south and
// sets phase_ticks to 40. Configuration is always ready.
module intersection_admission_controller #(
  parameter int unsigned MaxPerPath = iac_pkg::MaxPerPathDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [1:0] entry_direction_i,
  input  logic [1:0] turn_i,
  input  logic       emergency_vehicle_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       granted_o,
  output logic [1:0] light_phase_o,
  output logic       emerg_active_o,
  output logic [7:0] occupancy_total_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import iac_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  iac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  iac_datapath #(
    .MaxPerPath (MaxPerPath)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_i           (command_i),
    .entry_direction_i   (entry_direction_i),
    .turn_i              (turn_i),
    .emergency_vehicle_i (emergency_vehicle_i),
    .cfg_we_i            (cfg_we),
    .cfg_data_i          (cfg_data_i),
    .granted_o           (granted_o),
    .light_phase_o       (light_phase_o),
    .emerg_active_o      (emerg_active_o),
    .occupancy_total_o   (occupancy_total_o)
  );

endmodule

FILE: tb/sv/intersection_admission_controller_tb.sv
`timescale 1ns / 1ps
module intersection_admission_controller_tb;
  import iac_pkg::*;

  localparam int LaneMax = iac_pkg::MaxPerPathDefault;

  // exit direction per entry, packed {west, east, south, north}
  localparam logic [7:0] AheadExit = {DirEast, DirWest, DirNorth, DirSouth};
  localparam logic [7:0] LeftExit  = {DirNorth, DirSouth, DirWest, DirEast};
  localparam logic [7:0] RightExit = {DirSouth, DirNorth, DirEast, DirWest};

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] dir;
    logic [1:0] trn;
    logic       emv;
  } crossing_t;

  typedef struct packed {
    logic       granted;
    phase_e     light;
    logic       emg;
    logic [7:0] occ;
  } outcome_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] command_i;
  logic [1:0] entry_direction_i;
  logic [1:0] turn_i;
  logic       emergency_vehicle_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       granted_o;
  logic [1:0] light_phase_o;
  logic       emerg_active_o;
  logic [7:0] occupancy_total_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  intersection_admission_controller u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .entry_direction_i  (entry_direction_i),
    .turn_i             (turn_i),
    .emergency_vehicle_i(emergency_vehicle_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .granted_o          (granted_o),
    .light_phase_o      (light_phase_o),
    .emerg_active_o     (emerg_active_o),
    .occupancy_total_o  (occupancy_total_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  // intersection state as the controller should hold it
  logic [3:0] lane_cnt [12];
  phase_e     light;
  logic       emg_on;
  logic       clearing;
  logic [7:0] timer;
  logic [7:0] ticks;

  crossing_t arrivals[$];
  outcome_t  outcome_q[$];
  int        queued_total;
  int        accepted_total;
  int        counted;
  int        failures;
  logic      quiet;
  logic      in_fired;
  int        in_gap;
  int        out_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("intersection_admission_controller_tb NOT OK");
    $finish;
  end

  function automatic logic [1:0] leave_to(input logic [1:0] d, input logic [1:0] t);
    if (t == TurnStraight) return AheadExit[2*d +: 2];
    if (t == TurnRight) return RightExit[2*d +: 2];
    return LeftExit[2*d +: 2];
  endfunction

  function automatic logic facing(input logic [1:0] a, input logic [1:0] b);
    return (a ^ b) == 2'b01;
  endfunction

  function automatic logic paths_cross(input logic [1:0] d1, input logic [1:0] t1,
                                       input logic [1:0] d2, input logic [1:0] t2);
    if (d1 == d2) return 1'b1;
    if (leave_to(d1, t1) == leave_to(d2, t2)) return 1'b1;
    if (t1 == TurnRight || t2 == TurnRight) return 1'b0;
    if (t1 == TurnStraight && t2 == TurnStraight) return !facing(d1, d2);
    // a left turn cuts the straight flow arriving from its own exit side
    if (t1 == TurnLeft && t2 == TurnStraight) return LeftExit[2*d1 +: 2] == d2;
    if (t1 == TurnStraight && t2 == TurnLeft) return LeftExit[2*d2 +: 2] == d1;
    return facing(d1, d2);
  endfunction

  function automatic int lane_sum();
    int n;
    n = 0;
    for (int p = 0; p < 12; p++) n += lane_cnt[p];
    return n;
  endfunction

  function automatic void reset_model();
    for (int p = 0; p < 12; p++) lane_cnt[p] = '0;
    light    = PH_NS;
    emg_on   = 1'b0;
    clearing = 1'b0;
    timer    = '0;
    ticks    = PhaseTicksReset;
  endfunction

  function automatic outcome_t step_crossing(input crossing_t it);
    outcome_t v;
    int       slot;
    logic     room;
    logic     clear;
    phase_e   want;
    v.granted = 1'b0;
    slot = int'(it.dir) * 3 + int'(it.trn);
    case (it.cmd)
      CMD_REQUEST: if (it.trn != TurnNone) begin
        room = lane_cnt[slot] < LaneMax;
        if (it.emv) begin
          if (!emg_on) begin
            emg_on   = 1'b1;
            clearing = 1'b1;
            light    = PH_EMG;
          end
          if (clearing) begin
            if (lane_sum() == 0 && room) begin
              clearing  = 1'b0;
              v.granted = 1'b1;
            end
          end else begin
            v.granted = room;
          end
        end else if (!emg_on && room) begin
          want = (it.dir < DirEast) ? PH_NS : PH_EW;
          if (light == want) begin
            clear = 1'b1;
            for (int p = 0; p < 12; p++) begin
              if (lane_cnt[p] != 0 && paths_cross(it.dir, it.trn, 2'(p / 3), 2'(p % 3)))
                clear = 1'b0;
            end
            v.granted = clear;
          end
        end
        if (v.granted) lane_cnt[slot] = lane_cnt[slot] + 4'd1;
      end
      CMD_LEAVE: if (it.trn != TurnNone) begin
        if (lane_cnt[slot] != 0) lane_cnt[slot] = lane_cnt[slot] - 4'd1;
        if (it.emv && emg_on) begin
          emg_on   = 1'b0;
          clearing = 1'b0;
          light    = PH_NS;
          timer    = '0;
        end
      end
      CMD_TICK: if (!emg_on) begin
        timer = timer + 8'd1;
        // a setting of zero toggles on every tick, as one does
        if (timer >= ticks) begin
          light = (light == PH_NS) ? PH_EW : PH_NS;
          timer = '0;
        end
      end
      default: begin
        emg_on = 1'b1;
        light  = PH_EMG;
      end
    endcase
    v.light = light;
    v.emg   = emg_on;
    v.occ   = 8'(lane_sum());
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] any_turn();
    if ($urandom_range(0, 32) == 0) return TurnNone;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // input side, and the stall on the result side
  always @(negedge clk_i) begin : feeder
    crossing_t it;
    if (rst_ni) begin
      if (!in_valid_i || in_fired) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (arrivals.size() != 0) begin
          it = arrivals.pop_front();
          command_i           <= it.cmd;
          entry_direction_i   <= it.dir;
          turn_i              <= it.trn;
          emergency_vehicle_i <= it.emv;
          in_valid_i          <= 1'b1;
          in_gap = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_hold = idle_len();
        out_stall_i <= (out_hold != 0);
        if (out_hold != 0) out_hold--;
      end
    end
  end

  always @(posedge clk_i) begin : watcher
    crossing_t it;
    outcome_t  want;
    if (rst_ni) begin
      // results first: a result in the same cycle as an accept is always older
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result granted %0d phase %0d emergency %0d occupancy %0d",
                   $time, granted_o, light_phase_o, emerg_active_o, occupancy_total_o);
          failures++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("granted", want.granted, granted_o);
          compare_field("light_phase", want.light, light_phase_o);
          compare_field("emerg_active", want.emg, emerg_active_o);
          compare_field("occupancy_total", want.occ, occupancy_total_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        it.cmd = cmd_e'(command_i);
        it.dir = entry_direction_i;
        it.trn = turn_i;
        it.emv = emergency_vehicle_i;
        outcome_q.push_back(step_crossing(it));
        accepted_total++;
      end
      in_fired <= in_valid_i && !in_stall_o;
    end
  end

  task automatic send(input cmd_e c, input logic [1:0] d, input logic [1:0] t,
                      input logic e);
    crossing_t it;
    it.cmd = c;
    it.dir = d;
    it.trn = t;
    it.emv = e;
    arrivals.push_back(it);
    queued_total++;
    if (!((c == CMD_REQUEST || c == CMD_LEAVE) && t == TurnNone)) counted++;
  endtask

  task automatic send_noise();
    send(cmd_e'($urandom_range(0, 3)), 2'($urandom), 2'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    while (accepted_total != queued_total || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_ticks(input logic [7:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    ticks = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ordinary traffic on the green pair, departures from occupied paths, ticks and some noise;
  task automatic plan_traffic();
    int         r;
    int         p;
    int         busy[$];
    logic [1:0] d;
    for (p = 0; p < 12; p++) if (lane_cnt[p] != 0) busy.push_back(p);
    if (emg_on && $urandom_range(0, 9) < 7)
      send(CMD_LEAVE, 2'($urandom), 2'($urandom_range(0, 2)), 1'b1);
    repeat ($urandom_range(4, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        d = (light == PH_EW) ? DirEast : DirNorth;
        d = d | 2'($urandom_range(0, 1));
        send(CMD_REQUEST, d, any_turn(), $urandom_range(0, 24) == 0);
      end else if (r < 75) begin
        if (busy.size() != 0) begin
          p = busy[$urandom_range(0, busy.size() - 1)];
          send(CMD_LEAVE, 2'(p / 3), 2'(p % 3), 1'b0);
        end else begin
          send(CMD_LEAVE, 2'($urandom), any_turn(), 1'b0);
        end
      end else if (r < 95) begin
        send(CMD_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic plan_emergency();
    if ($urandom_range(0, 1) != 0)
      send(CMD_PREEMPT, 2'($urandom), 2'($urandom), 1'($urandom));
    else
      send(CMD_REQUEST, 2'($urandom), 2'($urandom_range(0, 2)), 1'b1);
    repeat ($urandom_range(1, 4)) send(CMD_REQUEST, 2'($urandom), any_turn(), 1'b1);
    if ($urandom_range(0, 2) != 0)
      send(CMD_REQUEST, 2'($urandom), 2'($urandom_range(0, 2)), 1'b0);
    for (int p = 0; p < 12; p++)
      repeat (lane_cnt[p]) send(CMD_LEAVE, 2'(p / 3), 2'(p % 3), 1'b0);
    repeat ($urandom_range(1, 2)) send(CMD_REQUEST, 2'($urandom), any_turn(), 1'b1);
    send(CMD_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
    send(CMD_LEAVE, 2'($urandom), 2'($urandom_range(0, 2)), 1'b1);
  endtask

  // one path pushed up to or near its limit under preemption, then drained in part or whole
  task automatic plan_fill();
    int p;
    p = $urandom_range(0, 11);
    if (emg_on) send(CMD_LEAVE, 2'($urandom), 2'($urandom_range(0, 2)), 1'b1);
    send(CMD_PREEMPT, 2'($urandom), 2'($urandom), 1'($urandom));
    repeat ($urandom_range(14, 17)) send(CMD_REQUEST, 2'(p / 3), 2'(p % 3), 1'b1);
    repeat ($urandom_range(10, 17)) send(CMD_LEAVE, 2'(p / 3), 2'(p % 3), 1'b0);
    send(CMD_LEAVE, 2'($urandom), 2'($urandom_range(0, 2)), 1'b1);
  endtask

  task automatic plan_flood();
    if (emg_on) send(CMD_LEAVE, DirNorth, TurnStraight, 1'b1);
    for (int p = 0; p < 12; p++)
      repeat (lane_cnt[p]) send(CMD_LEAVE, 2'(p / 3), 2'(p % 3), 1'b0);
    send(CMD_PREEMPT, DirNorth, TurnStraight, 1'b0);
    for (int p = 0; p < 12; p++)
      repeat (LaneMax) send(CMD_REQUEST, 2'(p / 3), 2'(p % 3), 1'b1);
    send(CMD_REQUEST, DirWest, TurnRight, 1'b1);
    for (int p = 0; p < 12; p++)
      repeat (LaneMax) send(CMD_LEAVE, 2'(p / 3), 2'(p % 3), 1'b0);
    send(CMD_LEAVE, DirEast, TurnLeft, 1'b1);
  endtask

  initial begin : stimulus
    int   r;
    int   next_cfg;
    int   cfg_round;
    logic flooded;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    command_i           = CMD_REQUEST;
    entry_direction_i   = DirNorth;
    turn_i              = TurnStraight;
    emergency_vehicle_i = 1'b0;
    out_stall_i         = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_data_i          = '0;
    in_fired            = 1'b0;
    in_gap              = 0;
    out_hold            = 0;
    queued_total        = 0;
    accepted_total      = 0;
    counted             = 0;
    failures            = 0;
    quiet               = 1'b0;
    flooded             = 1'b0;
    cfg_round           = 0;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, from reset with north-south green
    send(CMD_REQUEST, DirNorth, TurnStraight, 1'b0);
    send(CMD_REQUEST, DirSouth, TurnStraight, 1'b0);  // opposing straights coexist
    send(CMD_REQUEST, DirEast, TurnStraight, 1'b0);   // red
    send(CMD_REQUEST, DirNorth, TurnLeft, 1'b0);      // same entry
    send(CMD_REQUEST, DirSouth, TurnRight, 1'b0);
    send(CMD_REQUEST, DirNorth, TurnNone, 1'b1);
    send(CMD_LEAVE, DirWest, TurnNone, 1'b1);
    send(CMD_LEAVE, DirNorth, TurnStraight, 1'b0);
    send(CMD_LEAVE, DirSouth, TurnStraight, 1'b0);
    send(CMD_LEAVE, DirNorth, TurnStraight, 1'b0);    // already empty
    send(CMD_REQUEST, DirNorth, TurnLeft, 1'b0);
    send(CMD_REQUEST, DirSouth, TurnLeft, 1'b0);      // opposing lefts clash
    send(CMD_TICK, DirWest, TurnNone, 1'b1);
    send(CMD_REQUEST, DirSouth, TurnStraight, 1'b1);  // latches, must wait
    send(CMD_REQUEST, DirSouth, TurnStraight, 1'b0);
    send(CMD_TICK, DirNorth, TurnStraight, 1'b0);     // ignored in emergency
    send(CMD_LEAVE, DirNorth, TurnLeft, 1'b0);
    send(CMD_REQUEST, DirSouth, TurnStraight, 1'b1);  // now empty
    send(CMD_REQUEST, DirWest, TurnRight, 1'b1);
    send(CMD_LEAVE, DirSouth, TurnStraight, 1'b1);    // ends emergency
    send(CMD_LEAVE, DirWest, TurnRight, 1'b0);
    send(CMD_PREEMPT, DirWest, TurnNone, 1'b1);
    send(CMD_REQUEST, DirEast, TurnLeft, 1'b1);       // no clearing after preempt
    send(CMD_LEAVE, DirEast, TurnLeft, 1'b1);
    send(CMD_REQUEST, DirWest, TurnStraight, 1'b0);
    settle();

    counted  = 0;
    next_cfg = 250;
    while (counted < 2000) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (!flooded && counted > 1000) begin
        plan_flood();
        flooded = 1'b1;
      end else if (r < 50) begin
        plan_traffic();
      end else if (r < 65) begin
        if ($urandom_range(0, 4) == 0)
          repeat ((ticks == 0) ? 2 : int'(ticks) + 1)
            send(CMD_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
        else
          repeat ($urandom_range(1, 6))
            send(CMD_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
      end else if (r < 80) begin
        plan_emergency();
      end else if (r < 90) begin
        plan_fill();
      end else begin
        repeat ($urandom_range(3, 8)) send_noise();
      end
      settle();
      if (counted >= next_cfg) begin
        case (cfg_round)
          0:       write_ticks(8'd1);
          1:       write_ticks(8'd255);
          2:       write_ticks(8'd0);
          3:       write_ticks(8'd3);
          5:       write_ticks(PhaseTicksReset);
          default: write_ticks(8'($urandom_range(0, 12)));
        endcase
        cfg_round++;
        next_cfg += 250;
      end
    end

    settle();
    repeat (30) @(posedge clk_i);
    if (failures == 0) begin
      $display("intersection_admission_controller_tb OK");
    end else begin
      $display("intersection_admission_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
